// File: sv/fsp_pkg.sv
// Shared types, character codes and reset values for the format prefix parser.
package fsp_pkg;

  localparam int NUM_WIDTH    = 32;
  localparam int MAX_LEN_MODS = 2;
  localparam int PHASES       = 16;
  localparam int LM_CNT_W     = $clog2(MAX_LEN_MODS + 1);

  typedef logic [NUM_WIDTH-1:0] num_t;
  typedef logic [LM_CNT_W-1:0]  lm_cnt_t;
  typedef logic [PHASES-1:0]    phase_vec_t;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_Z  = 8'h7A;
  localparam logic [7:0] CH_LEN_L = 8'h6C;
  localparam logic [7:0] CH_LEN_H = 8'h68;
  localparam logic [7:0] CH_LEN_J = 8'h6A;
  localparam logic [7:0] CH_LEN_Z = 8'h7A;

  // Flag characters, entry 0 first: space + # 0 - $ L apostrophe.
  localparam logic [7:0][7:0] FLAG_CHARS = {
    8'h27, 8'h4C, 8'h24, 8'h2D, 8'h30, 8'h23, 8'h2B, 8'h20
  };

  localparam logic [1:0] PCT_NONE = 2'd0;
  localparam logic [1:0] PCT_ONE  = 2'd1;
  localparam logic [1:0] PCT_TWO  = 2'd2;

  typedef enum logic [PHASES-1:0] {
    PH_START = 16'h0001,
    PH_SPACE = 16'h0002,
    PH_PLUS  = 16'h0004,
    PH_HASH  = 16'h0008,
    PH_ZPAD  = 16'h0010,
    PH_MINUS = 16'h0020,
    PH_DOLL  = 16'h0040,
    PH_LDBL  = 16'h0080,
    PH_APOS  = 16'h0100,
    PH_WIDTH = 16'h0200,
    PH_WDIG  = 16'h0400,
    PH_DOT   = 16'h0800,
    PH_PREC  = 16'h1000,
    PH_PDIG  = 16'h2000,
    PH_LEN   = 16'h4000,
    PH_SKIP  = 16'h8000
  } phase_t;

  typedef struct packed {
    logic [7:0]                   flags;
    logic                         dot;
    num_t                         width;
    num_t                         prec;
    lm_cnt_t                      lm_cnt;
    logic [MAX_LEN_MODS-1:0][7:0] lm;
    phase_t                       phase;
    logic [1:0]                   pct_cnt;
    logic                         found;
    logic                         stopped;
  } state_t;

  typedef struct packed {
    phase_vec_t acc;     // phases that would take the character, skip phase excluded
    logic       letter;
    logic       nul;
    logic       pct;
    logic       star;
    logic [3:0] dval;
  } match_t;

  typedef struct packed {
    logic        consumed;
    logic        done_res;
    logic        arg_used;
    logic [7:0]  flag_bits;
    logic        precision_given;
    logic [31:0] field_width;
    logic [31:0] precision_value;
    logic [7:0]  len_mod_first;
    logic [7:0]  len_mod_second;
  } result_t;

  localparam state_t STATE_RESET = '{
    flags:   '0,
    dot:     1'b0,
    width:   '1,
    prec:    '1,
    lm_cnt:  '0,
    lm:      '0,
    phase:   PH_START,
    pct_cnt: PCT_NONE,
    found:   1'b0,
    stopped: 1'b0
  };

endpackage

// File: sv/fsp_if.sv
// Valid/ready channel interfaces for format characters and parse results.
interface fsp_in_if import fsp_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [7:0]  char_code;
  logic        start_new;
  logic [31:0] star_argument;

  modport source (output valid, output char_code, output start_new, output star_argument,
                  input ready);
  modport sink (input valid, input char_code, input start_new, input star_argument,
                output ready);
endinterface

interface fsp_out_if import fsp_pkg::*; ();
  logic        valid;
  logic        ready;
  logic        consumed;
  logic        done_res;
  logic        arg_used;
  logic [7:0]  flag_bits;
  logic        precision_given;
  logic [31:0] field_width;
  logic [31:0] precision_value;
  logic [7:0]  len_mod_first;
  logic [7:0]  len_mod_second;

  modport source (output valid, output consumed, output done_res, output arg_used,
                  output flag_bits, output precision_given, output field_width,
                  output precision_value, output len_mod_first, output len_mod_second,
                  input ready);
  modport sink (input valid, input consumed, input done_res, input arg_used,
                input flag_bits, input precision_given, input field_width,
                input precision_value, input len_mod_first, input len_mod_second,
                output ready);
endinterface

// File: sv/fsp_match.sv
// Character classifier: which parse phases would take the current character.
module fsp_match import fsp_pkg::*; (
  input  logic [7:0] char_code,
  input  logic       width_unset,
  input  lm_cnt_t    lm_cnt,
  output match_t     m
);

  logic digit;
  logic len_char;

  always_comb begin
    digit    = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
    len_char = (char_code == CH_LEN_L) || (char_code == CH_LEN_H) ||
               (char_code == CH_LEN_J) || (char_code == CH_LEN_Z);

    m.letter = ((char_code >= CH_UP_A) && (char_code <= CH_UP_Z)) ||
               ((char_code >= CH_LO_A) && (char_code <= CH_LO_Z));
    m.nul    = (char_code == CH_NUL);
    m.pct    = (char_code == CH_PCT);
    m.star   = (char_code == CH_STAR);
    m.dval   = 4'(char_code - CH_ZERO);

    m.acc = '0;
    for (int k = 0; k < 8; k++) begin
      if (char_code == FLAG_CHARS[k]) begin
        m.acc = m.acc | phase_vec_t'(PH_SPACE << k);
      end
    end
    // A leading zero is the zero flag, never the start of a width.
    if ((digit && (char_code != CH_ZERO) && width_unset) || m.star) begin
      m.acc = m.acc | PH_WIDTH;
    end
    if (digit) begin
      m.acc = m.acc | PH_WDIG | PH_PDIG;
    end
    if (char_code == CH_DOT) begin
      m.acc = m.acc | PH_DOT;
    end
    if (digit || m.star) begin
      m.acc = m.acc | PH_PREC;
    end
    if (len_char && (lm_cnt < lm_cnt_t'(MAX_LEN_MODS))) begin
      m.acc = m.acc | PH_LEN;
    end
  end

endmodule

// File: sv/fsp_step.sv
// Next-state logic: finds the first phase on the walk that takes the character.
module fsp_step import fsp_pkg::*; (
  input  state_t      s,
  input  match_t      m,
  input  logic [7:0]  char_code,
  input  logic [31:0] star_argument,
  output state_t      ns,
  output logic        consumed,
  output logic        arg_used
);

  phase_vec_t reach;
  phase_vec_t mask1;
  phase_vec_t hits1;
  phase_vec_t hits2;
  phase_vec_t sel;
  logic       hit1;
  logic       stop_cond;
  num_t       mul_src;
  num_t       times_ten;
  num_t       star_num;

  always_comb begin
    // Phases at or after the current one. The digit phases are entered only by a digit,
    // and the precision phase only through a dot.
    reach = ~(phase_vec_t'(s.phase) - phase_vec_t'(1));
    mask1 = reach & ~phase_vec_t'(PH_START) & ~((PH_WDIG | PH_PREC | PH_PDIG) & ~s.phase);
    if (s.phase == PH_START) begin
      mask1 = '0;
    end
    hits1 = (m.acc | ((!s.found && !m.letter && !m.nul) ? PH_SKIP : '0)) & mask1;
    hits2 = (m.acc | PH_SKIP) & ~(PH_START | PH_WDIG | PH_PREC | PH_PDIG);
    hit1  = |hits1;
    sel   = hit1 ? (hits1 & (~hits1 + phase_vec_t'(1)))
                 : (hits2 & (~hits2 + phase_vec_t'(1)));
    stop_cond = m.nul || m.letter || (s.pct_cnt >= PCT_TWO);

    mul_src   = (s.phase == PH_WDIG) ? s.width : s.prec;
    times_ten = num_t'(mul_src << 3) + num_t'(mul_src << 1) + num_t'(m.dval);
    star_num  = num_t'(signed'(star_argument));

    ns       = s;
    consumed = 1'b0;
    arg_used = 1'b0;

    if (s.stopped) begin
      ns = s;
    end else if (hit1 || (!stop_cond && !m.pct)) begin
      // A fresh pass clears the find mark before any test runs.
      ns.found = hit1 ? s.found : 1'b0;
      consumed = 1'b1;
      unique case (phase_t'(sel)) inside
        PH_SPACE, PH_PLUS, PH_HASH, PH_ZPAD, PH_MINUS, PH_DOLL, PH_LDBL, PH_APOS: begin
          ns.flags = s.flags | 8'(sel >> 1);
          ns.found = 1'b1;
          ns.phase = phase_t'(sel << 1);
        end
        PH_WIDTH: begin
          if (m.star) begin
            ns.width = star_num;
            arg_used = 1'b1;
            ns.phase = PH_DOT;
          end else begin
            ns.width = num_t'(m.dval);
            ns.found = 1'b1;
            ns.phase = PH_WDIG;
          end
        end
        PH_WDIG: begin
          ns.width = times_ten;
          ns.phase = PH_WDIG;
        end
        PH_DOT: begin
          ns.found = 1'b1;
          ns.dot   = 1'b1;
          ns.phase = PH_PREC;
        end
        PH_PREC: begin
          if (m.star) begin
            ns.prec  = star_num;
            arg_used = 1'b1;
            ns.phase = PH_LEN;
          end else begin
            ns.prec  = num_t'(m.dval);
            ns.phase = PH_PDIG;
          end
        end
        PH_PDIG: begin
          ns.prec  = times_ten;
          ns.phase = PH_PDIG;
        end
        PH_LEN: begin
          for (int i = 0; i < MAX_LEN_MODS; i++) begin
            if (s.lm_cnt == lm_cnt_t'(i)) begin
              ns.lm[i] = char_code;
            end
          end
          ns.lm_cnt = s.lm_cnt + lm_cnt_t'(1);
          ns.phase  = PH_LEN;
        end
        PH_SKIP: begin
          ns.phase = PH_START;
        end
        default: begin
          consumed = 1'b0;
        end
      endcase
    end else if (stop_cond) begin
      ns.stopped = 1'b1;
      ns.phase   = PH_START;
    end else if (s.pct_cnt == PCT_NONE) begin
      ns.found   = 1'b1;
      ns.pct_cnt = PCT_ONE;
      ns.phase   = PH_SPACE;
      consumed   = 1'b1;
    end else begin
      // A second percent sign matches nothing in its pass and ends the parse.
      ns.found   = 1'b1;
      ns.pct_cnt = PCT_TWO;
      ns.stopped = 1'b1;
      ns.phase   = PH_START;
    end
  end

endmodule

// File: sv/format_spec_prefix_parser.sv
// Top level of the printf conversion prefix parser: one format character per beat.
// The parser takes one format character per clock and returns one result beat per
// character, in order. A character is captured in an input register, classified and
// run through the phase walk in the next cycle, and written with the updated parse
// state into the result register, and characters can be accepted back to back, one
// per cycle, while results are taken. The rate is set by the phase walk, which is
// combinational and includes one multiply-by-ten add for the width or precision.
// A result that is not taken stalls the pipeline in place.
// Set start_new on the first character of each conversion to clear the parse state.
module format_spec_prefix_parser import fsp_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  fsp_in_if.sink    chars,
  fsp_out_if.source results
);

  logic        item_valid;
  logic [7:0]  item_char;
  logic        item_start;
  logic [31:0] item_star;
  state_t      state;
  logic        res_valid;
  result_t     res;

  logic        advance;
  state_t      cur;
  state_t      state_next;
  match_t      m;
  logic        step_consumed;
  logic        step_used;
  result_t     res_next;

  assign advance     = item_valid && (!res_valid || results.ready);
  assign chars.ready = !item_valid || advance;
  assign cur         = item_start ? STATE_RESET : state;

  fsp_match u_match (
    .char_code   (item_char),
    .width_unset (cur.width[NUM_WIDTH-1]),
    .lm_cnt      (cur.lm_cnt),
    .m           (m)
  );

  fsp_step u_step (
    .s             (cur),
    .m             (m),
    .char_code     (item_char),
    .star_argument (item_star),
    .ns            (state_next),
    .consumed      (step_consumed),
    .arg_used      (step_used)
  );

  always_comb begin
    res_next.consumed        = step_consumed;
    res_next.done_res        = state_next.stopped;
    res_next.arg_used        = step_used;
    res_next.flag_bits       = state_next.flags;
    res_next.precision_given = state_next.dot;
    res_next.field_width     = 32'(signed'(state_next.width));
    res_next.precision_value = 32'(signed'(state_next.prec));
    res_next.len_mod_first   = state_next.lm[0];
    res_next.len_mod_second  = state_next.lm[1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      res_valid  <= 1'b0;
      state      <= STATE_RESET;
    end else begin
      if (chars.valid && chars.ready) begin
        item_valid <= 1'b1;
      end else if (advance) begin
        item_valid <= 1'b0;
      end
      if (advance) begin
        res_valid <= 1'b1;
        state     <= state_next;
      end else if (results.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (chars.valid && chars.ready) begin
      item_char  <= chars.char_code;
      item_start <= chars.start_new;
      item_star  <= chars.star_argument;
    end
    if (advance) begin
      res <= res_next;
    end
  end

  assign results.valid           = res_valid;
  assign results.consumed        = res.consumed;
  assign results.done_res        = res.done_res;
  assign results.arg_used        = res.arg_used;
  assign results.flag_bits       = res.flag_bits;
  assign results.precision_given = res.precision_given;
  assign results.field_width     = res.field_width;
  assign results.precision_value = res.precision_value;
  assign results.len_mod_first   = res.len_mod_first;
  assign results.len_mod_second  = res.len_mod_second;

`ifndef SYNTHESIS
  a_stop_not_consumed: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !(res.consumed && res.done_res))
    else $error("stop character reported as consumed");

  a_arg_only_on_consume: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.arg_used) |-> res.consumed)
    else $error("star argument used without consuming a character");

  a_frozen_after_stop: assert property (@(posedge clk) disable iff (rst)
    (advance && !item_start && state.stopped) |=> (state == $past(state)))
    else $error("parse state changed after a stop");

  a_flags_grow: assert property (@(posedge clk) disable iff (rst)
    (advance && !item_start) |=>
      ((state.flags & $past(state.flags)) == $past(state.flags)))
    else $error("flag cleared within one conversion");

  a_len_mod_bound: assert property (@(posedge clk) disable iff (rst)
    state.lm_cnt <= lm_cnt_t'(MAX_LEN_MODS))
    else $error("too many length modifiers stored");
`endif

endmodule
